[rtl/core/assert_macros.svh]
// assertion macros shared by the tile renderer rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMPR_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tmpr check failed");
`define TMPR_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tmpr check failed");
`else
`define TMPR_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define TMPR_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

[rtl/core/tmpr_pkg.sv]
// shared types, sizes and codes of the 2bpp tile renderer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package tmpr_pkg;

	localparam int MAP_ENTRIES   = 512;
	localparam int PATTERN_TILES = 128;
	localparam int PATTERN_BYTES = PATTERN_TILES * 16;
	localparam int MAP_AW        = $clog2(MAP_ENTRIES);
	localparam int TILE_W        = $clog2(PATTERN_TILES);
	localparam int PLANE_AW      = TILE_W + 3;
	localparam int PLANE_DEPTH   = PATTERN_TILES * 8;
	localparam int CMP_W         = 14;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PW    = $clog2(CMD_DEPTH);
	localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);
	localparam int RES_DEPTH = 4;
	localparam int RES_PW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	localparam logic [14:0] PAL0_RST      = 15'h7F95;
	localparam logic [14:0] PAL1_RST      = 15'h322C;
	localparam logic [14:0] PAL2_RST      = 15'h0120;
	localparam logic [14:0] PAL3_RST      = 15'h0080;
	localparam logic [5:0]  MAP_WIDTH_RST = 6'd20;
	localparam logic [7:0]  TILE_BIAS_RST = 8'h35;

	typedef enum logic [1:0] {
		OP_MAP_WR = 2'd0,
		OP_PAT_WR = 2'd1,
		OP_PIX_RD = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		CFG_PAL0      = 3'd0,
		CFG_PAL1      = 3'd1,
		CFG_PAL2      = 3'd2,
		CFG_PAL3      = 3'd3,
		CFG_MAP_WIDTH = 3'd4,
		CFG_TILE_BIAS = 3'd5
	} cfg_index_t;

	typedef enum logic [1:0] {
		K_MAP_WR = 2'd0,
		K_PAT_WR = 2'd1,
		K_READ   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [10:0] write_address;
		logic [7:0]  write_data;
		logic [7:0]  pixel_x;
		logic [7:0]  pixel_y;
	} pixel_in_t;

	typedef struct packed {
		logic [14:0] color_rgb;
		logic [1:0]  color_index;
		logic        bad_tile;
	} pixel_out_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [10:0] addr;
		logic [7:0]  data;
		logic [2:0]  row;
		logic [2:0]  col;
		logic        oob;
	} cmd_t;

	typedef struct packed {
		logic [3:0][14:0] palette;
		logic [7:0]       tile_bias;
	} cfg_t;

endpackage

[rtl/core/tmpr_front.sv]
// front end: takes input transactions, classifies them, queues commands
// depends on tmpr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tmpr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tmpr_pkg::pixel_in_t item,
	input  logic [5:0]          map_width,
	input  logic                deq,
	output logic                head_valid,
	output tmpr_pkg::cmd_t      head
);
	import tmpr_pkg::*;

	cmd_t              cmd;
	logic              keep;
	logic              enq;
	logic [10:0]       map_prod;
	logic [10:0]       map_addr;
	cmd_t              mem_q [CMD_DEPTH];
	logic [CMD_PW-1:0] wr_ptr_q;
	logic [CMD_PW-1:0] rd_ptr_q;
	logic [CMD_CW-1:0] cnt_q;

	// tile address: row of tiles times map width plus tile column
	assign map_prod = 11'(item.pixel_y[7:3]) * 11'(map_width);
	assign map_addr = map_prod + 11'(item.pixel_x[7:3]);

	always_comb begin
		cmd      = '0;
		cmd.kind = K_MAP_WR;
		cmd.addr = item.write_address;
		cmd.data = item.write_data;
		cmd.row  = item.pixel_y[2:0];
		cmd.col  = item.pixel_x[2:0];
		cmd.oob  = 1'b0;
		keep     = 1'b0;
		case (item.opcode)
			OP_MAP_WR: begin
				cmd.kind = K_MAP_WR;
				keep     = CMP_W'(item.write_address) < CMP_W'(MAP_ENTRIES);
			end
			OP_PAT_WR: begin
				cmd.kind = K_PAT_WR;
				keep     = CMP_W'(item.write_address) < CMP_W'(PATTERN_BYTES);
			end
			OP_PIX_RD: begin
				cmd.kind = K_READ;
				cmd.addr = map_addr;
				cmd.oob  = CMP_W'(map_addr) >= CMP_W'(MAP_ENTRIES);
				keep     = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full       = cnt_q == CMD_CW'(CMD_DEPTH);
	assign enq        = push && !full && keep;
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	`TMPR_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CMD_CW'(CMD_DEPTH))
	`TMPR_ASSERT_NXT(a_cnt_up, clk, arst_n, enq && !deq, cnt_q == $past(cnt_q) + 1'b1)

endmodule

[rtl/core/tmpr_res_queue.sv]
// result queue between the render pipeline and the output ports
// depends on tmpr_pkg
`timescale 1ns / 1ps
module tmpr_res_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  tmpr_pkg::pixel_out_t wdata,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output tmpr_pkg::pixel_out_t rdata
);
	import tmpr_pkg::*;

	pixel_out_t        mem_q [RES_DEPTH];
	logic [RES_PW-1:0] wr_ptr_q;
	logic [RES_PW-1:0] rd_ptr_q;
	logic [RES_CW-1:0] cnt_q;
	logic              rd;

	assign full  = cnt_q == RES_CW'(RES_DEPTH);
	assign empty = cnt_q == '0;
	assign rd    = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == RES_PW'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == RES_PW'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/core/tmpr_back.sv]
// back end: map store, pattern planes and palette lookup in two stages
// depends on tmpr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tmpr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tmpr_pkg::cfg_t       cfg,
	input  logic                 head_valid,
	input  tmpr_pkg::cmd_t       head,
	output logic                 deq,
	input  logic                 res_full,
	output logic                 res_wr,
	output tmpr_pkg::pixel_out_t res_data
);
	import tmpr_pkg::*;

	logic [7:0]          map_mem   [MAP_ENTRIES];
	logic [7:0]          lo_mem    [PLANE_DEPTH];
	logic [7:0]          hi_mem    [PLANE_DEPTH];

	logic                en;
	logic                valid_s1;
	cmd_t                cmd_s1;
	logic [7:0]          map_byte_s1;
	logic [8:0]          diff;
	logic [7:0]          tile;
	logic                bad;
	logic [PLANE_AW-1:0] rd_idx;
	logic [PLANE_AW-1:0] wr_idx;

	logic                valid_s2;
	logic                bad_s2;
	logic [2:0]          col_s2;
	logic [7:0]          lo_byte_s2;
	logic [7:0]          hi_byte_s2;
	logic [2:0]          sh;
	logic [1:0]          idx;
	logic [14:0]         pal;

	// whole pipeline freezes only while a finished pixel cannot be queued
	assign en  = !(valid_s2 && res_full);
	assign deq = en && head_valid;

	// map store: written and read as a command enters stage 1
	always_ff @(posedge clk) begin
		if (deq) begin
			if (head.kind == K_MAP_WR) begin
				map_mem[head.addr[MAP_AW-1:0]] <= head.data;
			end
			map_byte_s1 <= map_mem[head.addr[MAP_AW-1:0]];
		end
	end

	// tile number and range checks
	assign diff   = {1'b0, map_byte_s1} - {1'b0, cfg.tile_bias};
	assign tile   = diff[7:0];
	assign bad    = cmd_s1.oob || diff[8] || ({1'b0, tile} >= 9'(PATTERN_TILES));
	assign rd_idx = {tile[TILE_W-1:0], cmd_s1.row};
	assign wr_idx = PLANE_AW'(cmd_s1.addr >> 1);

	// pattern planes: even bytes low plane, odd bytes high plane
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			if (cmd_s1.kind == K_PAT_WR) begin
				if (cmd_s1.addr[0]) begin
					hi_mem[wr_idx] <= cmd_s1.data;
				end else begin
					lo_mem[wr_idx] <= cmd_s1.data;
				end
			end
			lo_byte_s2 <= lo_mem[rd_idx];
			hi_byte_s2 <= hi_mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= head_valid;
			valid_s2 <= valid_s1 && (cmd_s1.kind == K_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= head;
			bad_s2 <= bad;
			col_s2 <= cmd_s1.col;
		end
	end

	// leftmost pixel is the msb
	assign sh  = 3'd7 - col_s2;
	assign idx = {hi_byte_s2[sh], lo_byte_s2[sh]};
	assign pal = cfg.palette[idx];

	always_comb begin
		res_data = '0;
		if (!bad_s2) begin
			res_data.color_rgb   = {pal[4:0], pal[9:5], pal[14:10]};
			res_data.color_index = idx;
		end
		res_data.bad_tile = bad_s2;
	end

	assign res_wr = valid_s2 && en;

	`TMPR_ASSERT_NXT(a_stall_hold, clk, arst_n, valid_s2 && !en, valid_s2 && $stable(bad_s2))
	`TMPR_ASSERT_IMP(a_bad_blank, clk, arst_n, res_wr && res_data.bad_tile, res_data.color_rgb == '0 && res_data.color_index == '0)
	`TMPR_ASSERT_NXT(a_wr_no_res, clk, arst_n, en && valid_s1 && cmd_s1.kind != K_READ, !valid_s2)

endmodule

[rtl/core/tile_map_pixel_renderer_2bpp.sv]
// top level of the planar 2bpp tile-map background renderer
// depends on tmpr_pkg, tmpr_front, tmpr_back, tmpr_res_queue
//
// usage
//  input channel: queue style, a transaction is taken when push is high and full low;
//   opcode selects map byte write, pattern byte write or pixel read, opcode 3 is dropped
//  result channel: queue style, the oldest pixel sits on result while empty is low
//   and leaves when pop is high; only pixel reads make a result
//  config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, ready is always high;
//   write only while the block is idle
//  latency: a pixel read taken at edge n is on result after edge n+3 when nothing stalls
//  throughput: one transaction per cycle, set by the single read port of each store
//   (map store in stage 1, both pattern planes in stage 2)
//  stalls: if pop stays low the four-deep result queue fills, the two render stages
//   freeze, the four-deep command queue fills and full rises
//  reset: queues empty, pipeline empty, palette, map width and tile bias take their
//   defaults; map and pattern stores are not cleared and hold garbage until written
`timescale 1ns / 1ps
module tile_map_pixel_renderer_2bpp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  tmpr_pkg::pixel_in_t  item,
	output logic                 empty,
	input  logic                 pop,
	output tmpr_pkg::pixel_out_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [14:0]          cfg_data
);
	import tmpr_pkg::*;

	logic [3:0][14:0] palette_q;
	logic [5:0]       map_width_q;
	logic [7:0]       tile_bias_q;
	cfg_t             cfg;

	logic             head_valid;
	cmd_t             head;
	logic             deq;
	logic             res_full;
	logic             res_wr;
	pixel_out_t       res_data;

	// config registers, always ready; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_q[0] <= PAL0_RST;
			palette_q[1] <= PAL1_RST;
			palette_q[2] <= PAL2_RST;
			palette_q[3] <= PAL3_RST;
			map_width_q  <= MAP_WIDTH_RST;
			tile_bias_q  <= TILE_BIAS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PAL0:      palette_q[0] <= cfg_data;
				CFG_PAL1:      palette_q[1] <= cfg_data;
				CFG_PAL2:      palette_q[2] <= cfg_data;
				CFG_PAL3:      palette_q[3] <= cfg_data;
				CFG_MAP_WIDTH: map_width_q  <= cfg_data[5:0];
				CFG_TILE_BIAS: tile_bias_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.palette   = palette_q;
	assign cfg.tile_bias = tile_bias_q;

	// front: classify, compute the map address, drop out-of-range writes
	tmpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.map_width  (map_width_q),
		.deq        (deq),
		.head_valid (head_valid),
		.head       (head)
	);

	// back: store accesses in transaction order, then palette lookup
	tmpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head_valid (head_valid),
		.head       (head),
		.deq        (deq),
		.res_full   (res_full),
		.res_wr     (res_wr),
		.res_data   (res_data)
	);

	// output queue decouples the pipeline from the receiver
	tmpr_res_queue u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_data),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.rdata  (result)
	);

endmodule
